### rtl/bld_pkg.sv
// shared constants, codes and helpers for the bounded levenshtein distance block
package bld_pkg;

  localparam int FUNC_W   = 2;
  localparam int CH_W     = 8;
  localparam int CUTOFF_W = 7;
  localparam int DIST_W   = 7;

  localparam int MAX_LEN_DEF = 64;

  localparam logic [FUNC_W-1:0] FUNC_APPEND_FIRST  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_APPEND_SECOND = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_COMPUTE       = 2'd2;

  localparam logic [DIST_W-1:0] DIST_MAX = 7'd127;

  // address width of a store with at least one address bit
  function automatic int clog2_min1(input int depth);
    return (depth <= 1) ? 1 : $clog2(depth);
  endfunction

endpackage

### rtl/bld_in_if.sv
// input channel: valid/ready handshake with func, ch and cutoff
interface bld_in_if;
  import bld_pkg::*;

  logic                valid;
  logic                ready;
  logic [FUNC_W-1:0]   func;
  logic [CH_W-1:0]     ch;
  logic [CUTOFF_W-1:0] cutoff;

  modport source (output valid, output func, output ch, output cutoff, input ready);
  modport sink   (input valid, input func, input ch, input cutoff, output ready);
endinterface

### rtl/bld_out_if.sv
// result channel: valid/ready handshake with distance and flags
interface bld_out_if;
  import bld_pkg::*;

  logic              valid;
  logic              ready;
  logic [DIST_W-1:0] distance;
  logic              early_exit;
  logic              overflowed;

  modport source (output valid, output distance, output early_exit, output overflowed,
                  input ready);
  modport sink   (input valid, input distance, input early_exit, input overflowed,
                  output ready);
endinterface

### rtl/bld_store.sv
// character store: one write port, one registered read port
module bld_store #(
  parameter int DEPTH = bld_pkg::MAX_LEN_DEF,
  parameter int IDX_W = bld_pkg::clog2_min1(bld_pkg::MAX_LEN_DEF)
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [IDX_W-1:0]          waddr,
  input  logic [bld_pkg::CH_W-1:0]  wdata,
  input  logic [IDX_W-1:0]          raddr,
  output logic [bld_pkg::CH_W-1:0]  rdata
);
  import bld_pkg::*;

  logic [CH_W-1:0] mem [DEPTH];
  logic [CH_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;
endmodule

### rtl/bld_core.sv
// row-by-row edit distance sequencer with a single-row memory and one min3 cell unit
module bld_core #(
  parameter int MAX_LEN = bld_pkg::MAX_LEN_DEF,
  parameter int LEN_W   = $clog2(bld_pkg::MAX_LEN_DEF + 1),
  parameter int IDX_W   = bld_pkg::clog2_min1(bld_pkg::MAX_LEN_DEF)
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [LEN_W-1:0]         nl,
  input  logic [LEN_W-1:0]         ns,
  output logic [IDX_W-1:0]         lng_addr,
  input  logic [bld_pkg::CH_W-1:0] lng_data,
  output logic [IDX_W-1:0]         sht_addr,
  input  logic [bld_pkg::CH_W-1:0] sht_data,
  output logic                     done,
  output logic [LEN_W-1:0]         distance
);
  import bld_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INIT,
    S_ROW_START,
    S_ROW_LOAD,
    S_CELL_RD,
    S_CELL_WR,
    S_FINISH
  } state_t;

  state_t state_r, state_nxt;

  logic [LEN_W-1:0] nl_r, nl_nxt;
  logic [LEN_W-1:0] ns_r, ns_nxt;
  logic [LEN_W-1:0] i_r, i_nxt;
  logic [LEN_W-1:0] j_r, j_nxt;
  logic [LEN_W-1:0] diag_r, diag_nxt;
  logic [LEN_W-1:0] left_r, left_nxt;
  logic [LEN_W-1:0] res_r, res_nxt;
  logic [CH_W-1:0]  c_r, c_nxt;

  // row memory, updated in place
  logic [LEN_W-1:0] row_mem [MAX_LEN + 1];
  logic [LEN_W-1:0] row_rdata_r;
  logic             row_we;
  logic [LEN_W-1:0] row_waddr;
  logic [LEN_W-1:0] row_wdata;
  logic [LEN_W-1:0] row_raddr;

  logic [LEN_W-1:0] j_inc;
  logic [LEN_W-1:0] i_inc;
  logic [LEN_W:0]   cand_ins;
  logic [LEN_W:0]   cand_sub;
  logic [LEN_W:0]   cand_del;
  logic [LEN_W:0]   cand_min;
  logic [LEN_W-1:0] cell_min;

  assign j_inc = j_r + LEN_W'(1);
  assign i_inc = i_r + LEN_W'(1);

  assign lng_addr  = i_r[IDX_W-1:0];
  assign sht_addr  = j_r[IDX_W-1:0];
  assign row_raddr = j_inc;

  // min3 cell unit
  always_comb begin
    cand_ins = {1'b0, left_r} + (LEN_W+1)'(1);
    cand_sub = {1'b0, diag_r} + (LEN_W+1)'(c_r != sht_data);
    cand_del = {1'b0, row_rdata_r} + (LEN_W+1)'(1);
    cand_min = (cand_del < cand_ins) ? cand_del : cand_ins;
    if (cand_sub < cand_min) begin
      cand_min = cand_sub;
    end
    cell_min = cand_min[LEN_W-1:0];
  end

  always_comb begin
    state_nxt = state_r;
    nl_nxt    = nl_r;
    ns_nxt    = ns_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    diag_nxt  = diag_r;
    left_nxt  = left_r;
    res_nxt   = res_r;
    c_nxt     = c_r;
    row_we    = 1'b0;
    row_waddr = j_r;
    row_wdata = j_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          nl_nxt = nl;
          ns_nxt = ns;
          i_nxt  = '0;
          j_nxt  = LEN_W'(1);
          if (ns == '0) begin
            res_nxt   = nl;
            state_nxt = S_FINISH;
          end else begin
            state_nxt = S_INIT;
          end
        end
      end
      S_INIT: begin
        row_we    = 1'b1;
        row_waddr = j_r;
        row_wdata = j_r;
        if (j_r == ns_r) begin
          i_nxt     = '0;
          state_nxt = S_ROW_START;
        end else begin
          j_nxt = j_inc;
        end
      end
      S_ROW_START: begin
        state_nxt = S_ROW_LOAD;
      end
      S_ROW_LOAD: begin
        c_nxt     = lng_data;
        diag_nxt  = i_r;
        left_nxt  = i_inc;
        j_nxt     = '0;
        state_nxt = S_CELL_RD;
      end
      S_CELL_RD: begin
        state_nxt = S_CELL_WR;
      end
      S_CELL_WR: begin
        row_we    = 1'b1;
        row_waddr = j_inc;
        row_wdata = cell_min;
        left_nxt  = cell_min;
        diag_nxt  = row_rdata_r;
        if (j_inc == ns_r) begin
          if (i_inc == nl_r) begin
            res_nxt   = cell_min;
            state_nxt = S_FINISH;
          end else begin
            i_nxt     = i_inc;
            state_nxt = S_ROW_START;
          end
        end else begin
          j_nxt     = j_inc;
          state_nxt = S_CELL_RD;
        end
      end
      S_FINISH: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    nl_r   <= nl_nxt;
    ns_r   <= ns_nxt;
    i_r    <= i_nxt;
    j_r    <= j_nxt;
    diag_r <= diag_nxt;
    left_r <= left_nxt;
    res_r  <= res_nxt;
    c_r    <= c_nxt;
  end

  always_ff @(posedge clk) begin
    if (row_we) begin
      row_mem[row_waddr] <= row_wdata;
    end
    row_rdata_r <= row_mem[row_raddr];
  end

  assign done     = (state_r == S_FINISH);
  assign distance = res_r;
endmodule

### rtl/bounded_levenshtein_distance.sv
// top level of the bounded levenshtein distance block
// Append items (func 0 or 1) are taken one per cycle when no compute is running
// and no result is stalled on the output, and store one byte each; bytes past
// MAX_LEN are dropped and flagged in the next result. A compute item whose length
// difference exceeds cutoff answers in the next cycle with that difference and
// early_exit set. Otherwise the shared min3 cell unit walks the table row by row
// over one row memory, with a read state and a write state per table cell for the
// registered row and character reads; an empty shorter string goes straight to
// the result. Input is held off while a compute runs. Both stores and the overflow
// flag are emptied by every compute item.
module bounded_levenshtein_distance #(
  parameter int MAX_LEN = bld_pkg::MAX_LEN_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  bld_in_if.sink           in_chan,
  bld_out_if.source        out_chan
);
  import bld_pkg::*;

  localparam int LEN_W = $clog2(MAX_LEN + 1);
  localparam int IDX_W = clog2_min1(MAX_LEN);
  localparam int CW    = (LEN_W > CUTOFF_W) ? LEN_W : CUTOFF_W;
  localparam int SW    = (LEN_W > DIST_W) ? LEN_W : DIST_W;

  logic [LEN_W-1:0] len1_r, len1_nxt;
  logic [LEN_W-1:0] len2_r, len2_nxt;
  logic             ovf_r, ovf_nxt;
  logic             busy_r, busy_nxt;
  logic             swap_r, swap_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [DIST_W-1:0] dist_r, dist_nxt;
  logic             early_r, early_nxt;
  logic             ovfo_r, ovfo_nxt;

  logic             accept;
  logic             full1;
  logic             full2;
  logic             we1;
  logic             we2;
  logic             swap;
  logic [LEN_W-1:0] nl;
  logic [LEN_W-1:0] ns;
  logic [LEN_W-1:0] diff;
  logic             early;
  logic             core_start;
  logic [IDX_W-1:0] lng_addr;
  logic [IDX_W-1:0] sht_addr;
  logic [CH_W-1:0]  rdata1;
  logic [CH_W-1:0]  rdata2;
  logic [IDX_W-1:0] raddr1;
  logic [IDX_W-1:0] raddr2;
  logic             core_done;
  logic [LEN_W-1:0] core_dist;
  logic [LEN_W-1:0] sat_src;
  logic [DIST_W-1:0] dist_sat;

  assign in_chan.ready = !busy_r && (!out_valid_r || out_chan.ready);
  assign accept        = in_chan.valid && in_chan.ready;

  assign full1 = (len1_r == LEN_W'(MAX_LEN));
  assign full2 = (len2_r == LEN_W'(MAX_LEN));
  assign we1   = accept && (in_chan.func == FUNC_APPEND_FIRST) && !full1;
  assign we2   = accept && (in_chan.func == FUNC_APPEND_SECOND) && !full2;

  assign swap  = (len2_r > len1_r);
  assign nl    = swap ? len2_r : len1_r;
  assign ns    = swap ? len1_r : len2_r;
  assign diff  = nl - ns;
  assign early = (CW'(diff) > CW'(in_chan.cutoff));
  assign core_start = accept && (in_chan.func == FUNC_COMPUTE) && !early;

  assign sat_src  = busy_r ? core_dist : diff;
  assign dist_sat = (SW'(sat_src) > SW'(DIST_MAX)) ? DIST_MAX : DIST_W'(sat_src);

  assign raddr1 = swap_r ? sht_addr : lng_addr;
  assign raddr2 = swap_r ? lng_addr : sht_addr;

  bld_store #(
    .DEPTH (MAX_LEN),
    .IDX_W (IDX_W)
  ) u_store1 (
    .clk   (clk),
    .we    (we1),
    .waddr (len1_r[IDX_W-1:0]),
    .wdata (in_chan.ch),
    .raddr (raddr1),
    .rdata (rdata1)
  );

  bld_store #(
    .DEPTH (MAX_LEN),
    .IDX_W (IDX_W)
  ) u_store2 (
    .clk   (clk),
    .we    (we2),
    .waddr (len2_r[IDX_W-1:0]),
    .wdata (in_chan.ch),
    .raddr (raddr2),
    .rdata (rdata2)
  );

  bld_core #(
    .MAX_LEN (MAX_LEN),
    .LEN_W   (LEN_W),
    .IDX_W   (IDX_W)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (core_start),
    .nl       (nl),
    .ns       (ns),
    .lng_addr (lng_addr),
    .lng_data (swap_r ? rdata2 : rdata1),
    .sht_addr (sht_addr),
    .sht_data (swap_r ? rdata1 : rdata2),
    .done     (core_done),
    .distance (core_dist)
  );

  always_comb begin
    len1_nxt      = len1_r;
    len2_nxt      = len2_r;
    ovf_nxt       = ovf_r;
    busy_nxt      = busy_r;
    swap_nxt      = swap_r;
    out_valid_nxt = out_valid_r;
    dist_nxt      = dist_r;
    early_nxt     = early_r;
    ovfo_nxt      = ovfo_r;
    if (out_valid_r && out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (busy_r && core_done) begin
      busy_nxt      = 1'b0;
      out_valid_nxt = 1'b1;
      dist_nxt      = dist_sat;
    end
    if (accept) begin
      case (in_chan.func)
        FUNC_APPEND_FIRST: begin
          if (full1) begin
            ovf_nxt = 1'b1;
          end else begin
            len1_nxt = len1_r + LEN_W'(1);
          end
        end
        FUNC_APPEND_SECOND: begin
          if (full2) begin
            ovf_nxt = 1'b1;
          end else begin
            len2_nxt = len2_r + LEN_W'(1);
          end
        end
        FUNC_COMPUTE: begin
          early_nxt = early;
          ovfo_nxt  = ovf_r;
          swap_nxt  = swap;
          len1_nxt  = '0;
          len2_nxt  = '0;
          ovf_nxt   = 1'b0;
          if (early) begin
            out_valid_nxt = 1'b1;
            dist_nxt      = dist_sat;
          end else begin
            busy_nxt = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len1_r      <= '0;
      len2_r      <= '0;
      ovf_r       <= 1'b0;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      len1_r      <= len1_nxt;
      len2_r      <= len2_nxt;
      ovf_r       <= ovf_nxt;
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
    swap_r  <= swap_nxt;
    dist_r  <= dist_nxt;
    early_r <= early_nxt;
    ovfo_r  <= ovfo_nxt;
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.distance   = dist_r;
  assign out_chan.early_exit = early_r;
  assign out_chan.overflowed = ovfo_r;
endmodule
